>>> src/sdes_pkg.sv
// package: types, constants and permutation helpers for the s-des cbc cipher unit
`default_nettype none

package sdes_pkg;

   // configuration register indexes
   localparam logic CsrKey = 1'b0;
   localparam logic CsrIv  = 1'b1;

   // cipher direction codes
   localparam logic ModeEncrypt = 1'b0;
   localparam logic ModeDecrypt = 1'b1;

   // permutation tables, element [n-1] is the first entry (source bit, 1 = msb)
   typedef logic [7:0][3:0] tab8_type;
   typedef logic [9:0][3:0] tab10_type;
   typedef logic [3:0][3:0] tab4_type;

   localparam tab8_type  TabIp    = {4'd2, 4'd6, 4'd3, 4'd1, 4'd4, 4'd8, 4'd5, 4'd7};
   localparam tab8_type  TabIpInv = {4'd4, 4'd1, 4'd3, 4'd5, 4'd7, 4'd2, 4'd8, 4'd6};
   localparam tab10_type TabP10   = {4'd3, 4'd5, 4'd2, 4'd7, 4'd4,
                                     4'd10, 4'd1, 4'd9, 4'd8, 4'd6};
   localparam tab8_type  TabP8    = {4'd6, 4'd3, 4'd7, 4'd4, 4'd8, 4'd5, 4'd10, 4'd9};
   localparam tab8_type  TabEp    = {4'd4, 4'd1, 4'd2, 4'd3, 4'd2, 4'd3, 4'd4, 4'd1};
   localparam tab4_type  TabP4    = {4'd2, 4'd4, 4'd3, 4'd1};

   // s-boxes indexed by {row, col}, row-major, element [15] is row 0 col 0
   typedef logic [15:0][1:0] sbox_type;
   localparam sbox_type Sbox0 = {2'd1, 2'd0, 2'd3, 2'd2,
                                 2'd3, 2'd2, 2'd1, 2'd0,
                                 2'd0, 2'd2, 2'd1, 2'd3,
                                 2'd3, 2'd1, 2'd3, 2'd2};
   localparam sbox_type Sbox1 = {2'd0, 2'd1, 2'd2, 2'd3,
                                 2'd2, 2'd0, 2'd1, 2'd3,
                                 2'd3, 2'd0, 2'd1, 2'd0,
                                 2'd2, 2'd1, 2'd0, 2'd3};

   // round subkey pair
   typedef struct packed {
      logic [7:0] k1;
      logic [7:0] k2;
   } subkey_type;

   // 8-bit to 8-bit permutation
   function automatic logic [7:0] perm8(input logic [7:0] v, input tab8_type tab);
      logic [7:0] r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = v[3'(4'd8 - tab[7-i])];
      end
      return r;
   endfunction

   // 10-bit to 8-bit selection (p8)
   function automatic logic [7:0] perm10to8(input logic [9:0] v, input tab8_type tab);
      logic [7:0] r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = v[4'd10 - tab[7-i]];
      end
      return r;
   endfunction

   // 10-bit permutation (p10)
   function automatic logic [9:0] perm10(input logic [9:0] v, input tab10_type tab);
      logic [9:0] r;
      r = '0;
      for (int i = 0; i < 10; i++) begin
         r[9-i] = v[4'd10 - tab[9-i]];
      end
      return r;
   endfunction

   // 4-bit to 8-bit expansion (e/p)
   function automatic logic [7:0] expand4(input logic [3:0] v, input tab8_type tab);
      logic [7:0] r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = v[2'(4'd4 - tab[7-i])];
      end
      return r;
   endfunction

   // 4-bit permutation (p4)
   function automatic logic [3:0] perm4(input logic [3:0] v, input tab4_type tab);
      logic [3:0] r;
      r = '0;
      for (int i = 0; i < 4; i++) begin
         r[3-i] = v[2'(4'd4 - tab[3-i])];
      end
      return r;
   endfunction

   // derive k1 and k2 from the 10-bit key
   function automatic subkey_type key_schedule(input logic [9:0] key);
      logic [9:0]  p;
      logic [4:0]  l1;
      logic [4:0]  r1;
      logic [4:0]  l2;
      logic [4:0]  r2;
      subkey_type  sk;
      p  = perm10(key, TabP10);
      l1 = {p[8:5], p[9]};
      r1 = {p[3:0], p[4]};
      l2 = {l1[2:0], l1[4:3]};
      r2 = {r1[2:0], r1[4:3]};
      sk.k1 = perm10to8({l1, r1}, TabP8);
      sk.k2 = perm10to8({l2, r2}, TabP8);
      return sk;
   endfunction

endpackage

`default_nettype wire

>>> src/sdes_crypt.sv
// s-des core with cbc xor: one item through ip, two fk rounds and ip inverse
`default_nettype none

module sdes_crypt (
   input  logic [7:0]          data_in,
   input  logic                mode,
   input  logic [7:0]          chain,
   input  sdes_pkg::subkey_type keys,
   output logic [7:0]          data_out,
   output logic [7:0]          cipher_byte
);
   import sdes_pkg::*;

   // round function: e/p, key mix, s-boxes, p4
   function automatic logic [3:0] round_f(input logic [3:0] r, input logic [7:0] sk);
      logic [7:0] x;
      logic [1:0] s0;
      logic [1:0] s1;
      x  = expand4(r, TabEp) ^ sk;
      s0 = Sbox0[4'd15 - {x[7], x[4], x[6:5]}];
      s1 = Sbox1[4'd15 - {x[3], x[0], x[2:1]}];
      return perm4({s0, s1}, TabP4);
   endfunction

   // fk: left half mixed with round_f of the right half
   function automatic logic [7:0] fk(input logic [7:0] v, input logic [7:0] sk);
      return {v[7:4] ^ round_f(v[3:0], sk), v[3:0]};
   endfunction

   logic       dec;
   logic [7:0] pre;
   logic [7:0] ka;
   logic [7:0] kb;
   logic [7:0] ip_v;
   logic [7:0] f1;
   logic [7:0] f2;
   logic [7:0] core_out;

   // direction selects subkey order and which side of the core gets the chain xor
   always_comb begin
      dec      = (mode == ModeDecrypt);
      pre      = dec ? data_in : (data_in ^ chain);
      ka       = dec ? keys.k2 : keys.k1;
      kb       = dec ? keys.k1 : keys.k2;
      ip_v     = perm8(pre, TabIp);
      f1       = fk(ip_v, ka);
      f2       = fk({f1[3:0], f1[7:4]}, kb);
      core_out = perm8(f2, TabIpInv);
      data_out = dec ? (core_out ^ chain) : core_out;
      // the ciphertext byte of this item feeds the next chain value
      cipher_byte = dec ? data_in : core_out;
   end

endmodule

`default_nettype wire

>>> src/sdes_cbc_cipher_unit.sv
// top level of the s-des cbc cipher unit: input stage, core and result stage
//
//  channel   prefix  direction  payload
//  request   req_    in         data_in[7:0], mode, chain_start
//  response  rsp_    out        data_out[7:0]
//  config    csr_    in         index 0 cipher_key[9:0], index 1 init_vector[7:0]
//
// an item is accepted into an input register, passes the whole cipher as
// combinational logic and lands in a result register: rsp_valid rises once the
// item moves there, which waits while a stalled result occupies that register.
// one item per cycle is sustained while rsp_ready is high; the chain register
// updates as an item enters the result register, so the next item sees it.
// a stalled response holds its item; the input register still takes one more item.
// synchronous reset clears the key, iv, chain value and both valid flags.
`default_nettype none

module sdes_cbc_cipher_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_in,
   input  logic       req_mode,
   input  logic       req_chain_start,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_data_out,
   input  logic       csr_write_en,
   input  logic       csr_index,
   input  logic [9:0] csr_wdata
);
   import sdes_pkg::*;

   logic       s1_valid_ff;
   logic       s1_valid_in;
   logic [7:0] s1_data_ff;
   logic       s1_mode_ff;
   logic       s1_start_ff;
   logic       out_valid_ff;
   logic       out_valid_in;
   logic [7:0] out_data_ff;
   logic [9:0] key_ff;
   logic [9:0] key_in;
   logic [7:0] iv_ff;
   logic [7:0] iv_in;
   logic [7:0] prev_ff;
   logic [7:0] prev_in;
   logic       req_fire;
   logic       advance;
   logic [7:0] chain;
   logic [7:0] core_data;
   logic [7:0] core_cipher;
   subkey_type keys;

   // pipeline handshake
   always_comb begin
      advance      = s1_valid_ff && (!out_valid_ff || rsp_ready);
      req_ready    = !s1_valid_ff || advance;
      req_fire     = req_valid && req_ready;
      s1_valid_in  = req_fire || (s1_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_ready);
   end

   // configuration writes and chain update
   always_comb begin
      key_in  = key_ff;
      iv_in   = iv_ff;
      prev_in = advance ? core_cipher : prev_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CsrKey:  key_in = csr_wdata;
            CsrIv:   iv_in  = csr_wdata[7:0];
            default: key_in = key_ff;
         endcase
      end
   end

   // subkeys and chaining value for the item in the input register
   always_comb begin
      keys  = key_schedule(key_ff);
      chain = s1_start_ff ? iv_ff : prev_ff;
   end

   sdes_crypt u_crypt (
      .data_in     (s1_data_ff),
      .mode        (s1_mode_ff),
      .chain       (chain),
      .keys        (keys),
      .data_out    (core_data),
      .cipher_byte (core_cipher)
   );

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         key_ff       <= '0;
         iv_ff        <= '0;
         prev_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         key_ff       <= key_in;
         iv_ff        <= iv_in;
         prev_ff      <= prev_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_data_ff  <= req_data_in;
         s1_mode_ff  <= req_mode;
         s1_start_ff <= req_chain_start;
      end
      if (advance) begin
         out_data_ff <= core_data;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_data_out = out_data_ff;

endmodule

`default_nettype wire

>>> src/sdes_checker.sv
// port-level checker for the s-des cbc cipher unit, with its bind
`default_nettype none

module sdes_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_data_out
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out))
      else $error("stalled response changed");

   // reset empties the result stage
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // with the result stage empty the input side never blocks
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("request blocked while result stage empty");

   // an accepted item moves to the result stage when the response side is ready
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready ##1 rsp_ready) |=> rsp_valid)
      else $error("accepted item produced no response");

endmodule

bind sdes_cbc_cipher_unit sdes_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_data_out (rsp_data_out)
);

`default_nettype wire
